FILE: src/atrp_pkg.sv
package atrp_pkg;

  localparam int MAX_LINES    = 16;
  localparam int MAX_LINE_LEN = 128;

  // the line counter is 5 bits wide, so the usable limit saturates at 31
  localparam int LINE_CAP = (MAX_LINES < 31) ? MAX_LINES : 31;

  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'd32;
  localparam logic [7:0] CH_TILD = 8'd126;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_R    = 8'h52;

  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [4:0] LINE_CAP_V = 5'(LINE_CAP);
  localparam logic [7:0] LINE_LEN_V = 8'(MAX_LINE_LEN);

  typedef struct packed {
    logic done;
    logic ok;
    logic err;
  } atrp_verdict_t;

endpackage

FILE: src/at_response_parser.sv
// AT response parser. Each received byte is one transfer on s_*, and each
// produces exactly one result transfer on m_*: a status (not ready, response
// complete, syntax error), an OK/ERROR flag valid on completion, and the
// count of LF-terminated lines so far. Throughput is one byte per clock
// unless m_tready stalls the output. A byte passes the input register,
// then the result register; parser state, line count and line position
// update per byte between them. s_tready depends combinationally on m_tready.
module at_response_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [1:0] status, [2] is_ok, [7:3] lines_seen
);
  import atrp_pkg::*;

  logic          in_valid;
  logic [7:0]    in_byte;
  logic          advance;
  atrp_verdict_t verdict;
  logic [4:0]    lines_now;
  logic [1:0]    status_now;
  logic [7:0]    out_data;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  atrp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .in_byte (in_byte),
    .verdict (verdict)
  );

  atrp_lines u_lines (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .in_byte    (in_byte),
    .verdict    (verdict),
    .lines_seen (lines_now)
  );

  always_comb begin
    if (verdict.err) status_now = ST_ERR;
    else if (verdict.done) status_now = ST_DONE;
    else status_now = ST_BUSY;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {lines_now, verdict.done & verdict.ok, status_now};
    end
  end

  assign m_tdata = out_data;

endmodule

FILE: src/atrp_parse.sv
module atrp_parse (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic [7:0]             in_byte,
  output atrp_pkg::atrp_verdict_t verdict
);
  import atrp_pkg::*;

  localparam logic [4:0] PS_START   = 5'd0;
  localparam logic [4:0] PS_CR1     = 5'd1;
  localparam logic [4:0] PS_LF1     = 5'd2;
  localparam logic [4:0] PS_OK_O    = 5'd3;
  localparam logic [4:0] PS_ERR_E   = 5'd4;
  localparam logic [4:0] PS_PLUS    = 5'd5;
  localparam logic [4:0] PS_TEXT    = 5'd6;
  localparam logic [4:0] PS_TEXT_CR = 5'd7;
  localparam logic [4:0] PS_TEXT_LF = 5'd8;
  localparam logic [4:0] PS_END_CR  = 5'd9;
  localparam logic [4:0] PS_END_LF  = 5'd10;
  localparam logic [4:0] PS_ERR_R1  = 5'd11;
  localparam logic [4:0] PS_ERR_R2  = 5'd12;
  localparam logic [4:0] PS_ERR_O   = 5'd13;
  localparam logic [4:0] PS_ERR_R3  = 5'd14;
  localparam logic [4:0] PS_ERR_CR  = 5'd15;
  localparam logic [4:0] PS_OK_K    = 5'd16;
  localparam logic [4:0] PS_OK_CR   = 5'd17;

  logic [4:0] state;
  logic [4:0] step;
  logic [4:0] state_next;
  logic       prn;
  logic       err;
  logic       done;
  logic       ok;

  assign prn = in_byte inside {[CH_SP:CH_TILD]};

  always_comb begin
    step = state;
    err  = 1'b0;
    done = 1'b0;
    ok   = 1'b0;
    case (state)
      PS_CR1: begin
        if (in_byte == CH_LF) step = PS_LF1; else err = 1'b1;
      end
      PS_LF1: begin
        if (in_byte == CH_O) step = PS_OK_O;
        else if (in_byte == CH_E) step = PS_ERR_E;
        else if (in_byte == CH_PLUS) step = PS_PLUS;
        else err = 1'b1;
      end
      PS_OK_O: begin
        if (in_byte == CH_K) step = PS_OK_K; else err = 1'b1;
      end
      PS_ERR_E: begin
        if (in_byte == CH_R) step = PS_ERR_R1; else err = 1'b1;
      end
      PS_PLUS: begin
        if (prn) step = PS_TEXT; else err = 1'b1;
      end
      PS_TEXT: begin
        if (in_byte == CH_CR) step = PS_TEXT_CR;
        else if (prn) step = PS_TEXT;
        else err = 1'b1;
      end
      PS_TEXT_CR: begin
        if (in_byte == CH_LF) step = PS_TEXT_LF; else err = 1'b1;
      end
      PS_TEXT_LF: begin
        if (in_byte == CH_CR) step = PS_END_CR;
        else if (in_byte == CH_PLUS) step = PS_PLUS;
        else err = 1'b1;
      end
      PS_END_CR: begin
        if (in_byte == CH_LF) step = PS_END_LF; else err = 1'b1;
      end
      PS_END_LF: begin
        if (in_byte == CH_O) step = PS_OK_O;
        else if (in_byte == CH_E) step = PS_ERR_E;
        else err = 1'b1;
      end
      PS_ERR_R1: begin
        if (in_byte == CH_R) step = PS_ERR_R2; else err = 1'b1;
      end
      PS_ERR_R2: begin
        if (in_byte == CH_O) step = PS_ERR_O; else err = 1'b1;
      end
      PS_ERR_O: begin
        if (in_byte == CH_R) step = PS_ERR_R3; else err = 1'b1;
      end
      PS_ERR_R3: begin
        if (in_byte == CH_CR) step = PS_ERR_CR; else err = 1'b1;
      end
      PS_ERR_CR: begin
        if (in_byte == CH_LF) done = 1'b1; else err = 1'b1;
      end
      PS_OK_K: begin
        if (in_byte == CH_CR) step = PS_OK_CR; else err = 1'b1;
      end
      PS_OK_CR: begin
        if (in_byte == CH_LF) begin
          done = 1'b1;
          ok   = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        if (in_byte == CH_CR) step = PS_CR1; else err = 1'b1;
      end
    endcase
  end

  // a syntax error leaves the parser waiting for the same thing
  always_comb begin
    if (done) state_next = PS_START;
    else if (err) state_next = state;
    else state_next = step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PS_START;
    end else if (en) begin
      state <= state_next;
    end
  end

  assign verdict.done = done;
  assign verdict.ok   = ok;
  assign verdict.err  = err;

endmodule

FILE: src/atrp_lines.sv
module atrp_lines (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic [7:0]             in_byte,
  input  atrp_pkg::atrp_verdict_t verdict,
  output logic [4:0]             lines_seen
);
  import atrp_pkg::*;

  logic [7:0] char_pos;
  logic [7:0] char_pos_next;
  logic [4:0] line_total;
  logic [4:0] line_total_next;

  // counting freezes at the line limit or at a full-length line
  always_comb begin
    char_pos_next   = char_pos;
    line_total_next = line_total;
    if (line_total < LINE_CAP_V && char_pos < LINE_LEN_V) begin
      if (in_byte == CH_LF) begin
        line_total_next = line_total + 5'd1;
        char_pos_next   = '0;
      end else begin
        char_pos_next = char_pos + 8'd1;
      end
    end
  end

  assign lines_seen = line_total_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_pos   <= '0;
      line_total <= '0;
    end else if (en) begin
      if (verdict.done) begin
        char_pos   <= '0;
        line_total <= '0;
      end else begin
        char_pos   <= char_pos_next;
        line_total <= line_total_next;
      end
    end
  end

endmodule

FILE: src/atrp_checker.sv
module atrp_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);
  import atrp_pkg::*;

  logic unused_in;
  assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata);

  a_no_out_after_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == ST_BUSY || m_tdata[1:0] == ST_DONE ||
                  m_tdata[1:0] == ST_ERR))
    else $error("bad status code");

  a_ok_only_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> m_tdata[1:0] == ST_DONE)
    else $error("is_ok set without completion");

  a_line_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:3] <= LINE_CAP_V)
    else $error("line count beyond limit");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind at_response_parser atrp_checker u_atrp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: dv/at_response_checker.sv
// Watches both channels of the parser, predicts the result of every accepted
// byte and compares it, field by field, with the next result transfer.
module at_response_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [1:0] status, [2] is_ok, [7:3] lines_seen
  output int         fail_count,
  output int         results_pending
);
  import atrp_pkg::*;

  typedef enum logic [4:0] {
    G_START, G_CR1, G_LF1, G_OK_O, G_ERR_E, G_PLUS, G_TEXT, G_TEXT_CR,
    G_TEXT_LF, G_END_CR, G_END_LF, G_ERR_R1, G_ERR_R2, G_ERR_O, G_ERR_R3,
    G_ERR_CR, G_OK_K, G_OK_CR
  } grammar_pos_t;

  // first member lands in the highest bits
  typedef struct packed {
    logic [4:0] lines;
    logic       is_ok;
    logic [1:0] status;
  } parse_result_t;

  grammar_pos_t  gpos;
  logic [7:0]    char_pos;
  logic [4:0]    line_cnt;
  parse_result_t pending_results [$];
  parse_result_t want;
  parse_result_t got;
  int            mismatches;
  int            results_checked;

  initial begin
    fail_count      = 0;
    results_pending = 0;
    mismatches      = 0;
    results_checked = 0;
  end

  task report_mismatch(input string what, input logic [7:0] seen, input logic [7:0] exp);
    $display("%0t: result %0d %s: got 0x%0h expected 0x%0h", $time, results_checked, what,
             seen, exp);
    mismatches = mismatches + 1;
  endtask

  task advance_parser(input logic [7:0] c, output parse_result_t r);
    grammar_pos_t nxt;
    logic         bad;
    logic         done;
    logic         ok_word;
    logic         prn;
    nxt     = gpos;
    bad     = 1'b0;
    done    = 1'b0;
    ok_word = 1'b0;
    prn     = (c >= CH_SP) && (c <= CH_TILD);

    // line bookkeeping runs on every byte, whatever the grammar says
    if (line_cnt < LINE_CAP_V && char_pos < LINE_LEN_V) begin
      char_pos = char_pos + 8'd1;
      if (c == CH_LF) begin
        line_cnt = line_cnt + 5'd1;
        char_pos = 8'd0;
      end
    end
    r.lines = line_cnt;

    case (gpos)
      G_CR1:     if (c == CH_LF) nxt = G_LF1; else bad = 1'b1;
      G_LF1: begin
        if (c == CH_O) nxt = G_OK_O;
        else if (c == CH_E) nxt = G_ERR_E;
        else if (c == CH_PLUS) nxt = G_PLUS;
        else bad = 1'b1;
      end
      G_OK_O:    if (c == CH_K) nxt = G_OK_K; else bad = 1'b1;
      G_ERR_E:   if (c == CH_R) nxt = G_ERR_R1; else bad = 1'b1;
      G_PLUS:    if (prn) nxt = G_TEXT; else bad = 1'b1;
      G_TEXT: begin
        if (c == CH_CR) nxt = G_TEXT_CR;
        else if (prn) nxt = G_TEXT;
        else bad = 1'b1;
      end
      G_TEXT_CR: if (c == CH_LF) nxt = G_TEXT_LF; else bad = 1'b1;
      G_TEXT_LF: begin
        if (c == CH_CR) nxt = G_END_CR;
        else if (c == CH_PLUS) nxt = G_PLUS;
        else bad = 1'b1;
      end
      G_END_CR:  if (c == CH_LF) nxt = G_END_LF; else bad = 1'b1;
      G_END_LF: begin
        if (c == CH_O) nxt = G_OK_O;
        else if (c == CH_E) nxt = G_ERR_E;
        else bad = 1'b1;
      end
      G_ERR_R1:  if (c == CH_R) nxt = G_ERR_R2; else bad = 1'b1;
      G_ERR_R2:  if (c == CH_O) nxt = G_ERR_O; else bad = 1'b1;
      G_ERR_O:   if (c == CH_R) nxt = G_ERR_R3; else bad = 1'b1;
      G_ERR_R3:  if (c == CH_CR) nxt = G_ERR_CR; else bad = 1'b1;
      G_ERR_CR:  if (c == CH_LF) done = 1'b1; else bad = 1'b1;
      G_OK_K:    if (c == CH_CR) nxt = G_OK_CR; else bad = 1'b1;
      G_OK_CR: begin
        if (c == CH_LF) begin
          done    = 1'b1;
          ok_word = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      default:   if (c == CH_CR) nxt = G_CR1; else bad = 1'b1;
    endcase

    // a syntax error leaves the grammar position where it was
    if (done) begin
      gpos     = G_START;
      line_cnt = 5'd0;
      char_pos = 8'd0;
    end else if (!bad) begin
      gpos = nxt;
    end

    r.status = bad ? ST_ERR : (done ? ST_DONE : ST_BUSY);
    r.is_ok  = done && ok_word;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      gpos     = G_START;
      char_pos = 8'd0;
      line_cnt = 5'd0;
      pending_results.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        advance_parser(s_tdata, want);
        pending_results.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_results.size() == 0) begin
          report_mismatch("transfer with no result expected", m_tdata, 8'h00);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 8'(got.status), 8'(want.status));
          if (got.is_ok !== want.is_ok)
            report_mismatch("is_ok", 8'(got.is_ok), 8'(want.is_ok));
          if (got.lines !== want.lines)
            report_mismatch("lines_seen", 8'(got.lines), 8'(want.lines));
        end
        results_checked = results_checked + 1;
      end
    end
    fail_count      <= mismatches;
    results_pending <= pending_results.size();
  end

endmodule

FILE: dv/tb_at_response_parser.sv
module tb_at_response_parser;
  import atrp_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int ITEM_COUNT = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [1:0] status, [2] is_ok, [7:3] lines_seen
  int         fail_count;
  int         results_pending;
  int         bytes_sent = 0;
  int         burst_left = 0;
  int         idle_cycles = 0;

  // NUL, an OK response, an ERROR response, then one info line with both
  // printable extremes and a bad byte inside the text, then CR LF OK CR LF
  logic [7:0] directed_bytes [30] = '{
    8'h00,
    CH_CR, CH_LF, CH_O, CH_K, CH_CR, CH_LF,
    CH_CR, CH_LF, CH_E, CH_R, CH_R, CH_O, CH_R, CH_CR, CH_LF,
    CH_CR, CH_LF, CH_PLUS, CH_SP, CH_TILD, 8'hFF, CH_CR, CH_LF,
    CH_CR, CH_LF, CH_O, CH_K, CH_CR, CH_LF
  };

  always #2 clk = ~clk;

  at_response_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  at_response_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  // offers one byte and returns at the edge where the transfer happens
  task send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(150, 300)
                                                : $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    burst_left = burst_left - 1;
    bytes_sent = bytes_sent + 1;
  endtask

  initial begin
    logic [7:0] resp [$];
    int         pick;
    int         nlines;
    int         tlen;
    int         cut;
    int         n;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_bytes[k]) send_byte(directed_bytes[k]);

    while (bytes_sent < ITEM_COUNT) begin
      resp.delete();
      if ($urandom_range(0, 99) < 75) begin
        resp.push_back(CH_CR);
        resp.push_back(CH_LF);
        pick = $urandom_range(0, 99);
        nlines = (pick < 40) ? 0 : (pick < 88) ? $urandom_range(1, 4) : $urandom_range(14, 19);
        for (int i = 0; i < nlines; i++) begin
          resp.push_back(CH_PLUS);
          // now and then a long line, at times long enough to reach the length limit
          tlen = ($urandom_range(0, 29) == 0) ? $urandom_range(120, 140) : $urandom_range(1, 10);
          for (int j = 0; j < tlen; j++) resp.push_back(8'($urandom_range(32, 126)));
          resp.push_back(CH_CR);
          resp.push_back(CH_LF);
        end
        if (nlines > 0) begin
          resp.push_back(CH_CR);
          resp.push_back(CH_LF);
        end
        if ($urandom_range(0, 1) == 0) begin
          resp.push_back(CH_O);
          resp.push_back(CH_K);
        end else begin
          resp.push_back(CH_E);
          resp.push_back(CH_R);
          resp.push_back(CH_R);
          resp.push_back(CH_O);
          resp.push_back(CH_R);
        end
        resp.push_back(CH_CR);
        resp.push_back(CH_LF);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          resp[$urandom_range(0, resp.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (pick < 14) begin
          cut = $urandom_range(1, resp.size() - 1);
          while (resp.size() > cut) void'(resp.pop_back());
        end
      end else begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) resp.push_back(8'($urandom_range(0, 255)));
      end
      foreach (resp[k]) send_byte(resp[k]);
    end
    s_tvalid <= 1'b0;

    do @(posedge clk); while (results_pending != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_at_response_parser passed");
    end else begin
      $display("tb_at_response_parser failed");
    end
    $finish;
  end

  // result side: random stall patterns from four modes, plus long hold-offs
  initial begin
    int cyc;
    int hold_left;
    int mode;
    cyc       = 0;
    hold_left = 0;
    mode      = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (cyc == 600 || cyc == 4000) hold_left = 400;
      if (cyc % 256 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        m_tready  <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 1) == 0);
          2:       m_tready <= ($urandom_range(0, 9) != 0);
          default: m_tready <= (cyc % 5 != 0);
        endcase
      end
      cyc = cyc + 1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_at_response_parser failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
